>>> hw/rtl/im2col_tile8_address_generator_core_macros.svh
// Assertion macros for the im2col tile address generator RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef IM2COL_TILE8_ADDRESS_GENERATOR_CORE_MACROS_SVH
`define IM2COL_TILE8_ADDRESS_GENERATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define IM2COL_AG_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IM2COL_AG_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define IM2COL_AG_ASSERT(lbl, clk, rstn, prop, msg)
`define IM2COL_AG_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

>>> hw/rtl/im2col_ag_pkg.sv
// Shared widths, types and helpers of the im2col tile address generator.
// No dependencies; used by the divider, the lane datapath and the top level.
package im2col_ag_pkg;

	localparam int LANES        = 8;
	localparam int DIVIDEND_W   = 24;
	localparam int DIM_W        = 13;
	localparam int SMALL_W      = 4;
	localparam int CHAN_W       = 10;
	localparam int KOFF_W       = 8;
	localparam int ROW_W        = DIVIDEND_W + 1;
	localparam int ROW_PROD_W   = ROW_W + SMALL_W;
	localparam int COL_PROD_W   = DIM_W + SMALL_W;
	localparam int Y_W          = ROW_PROD_W + 2;
	localparam int X_W          = COL_PROD_W + 2;
	localparam int PLANE_W      = 2 * DIM_W;
	localparam int ADDR_W       = 34;
	localparam int DIV_STEP     = 2;
	localparam int DIV_STAGES   = DIVIDEND_W / DIV_STEP;
	localparam int LATENCY      = DIV_STAGES + 5;

	typedef enum logic [2:0] {
		REG_INPUT_WIDTH  = 3'd0,
		REG_INPUT_HEIGHT = 3'd1,
		REG_OUTPUT_WIDTH = 3'd2,
		REG_STRIDE_X     = 3'd3,
		REG_STRIDE_Y     = 3'd4,
		REG_PAD_LEFT     = 3'd5,
		REG_PAD_TOP      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [KOFF_W-1:0] ky;
		logic [KOFF_W-1:0] kx;
	} side_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [DIM_W-1:0] col;
	} pos_t;

	typedef struct packed {
		logic [DIM_W-1:0]   input_width;
		logic [DIM_W-1:0]   input_height;
		logic [SMALL_W-1:0] stride_x;
		logic [SMALL_W-1:0] stride_y;
		logic [SMALL_W-1:0] pad_left;
		logic [SMALL_W-1:0] pad_top;
		logic               ow_nz;
	} lane_cfg_t;

	// advance one output position, wrapping the column at the output width
	function automatic pos_t next_pos(pos_t p, logic [DIM_W-1:0] ow);
		pos_t             r;
		logic [DIM_W-1:0] c1;
		c1 = DIM_W'(p.col + 1'b1);
		if (c1 == ow) begin
			r.row = ROW_W'(p.row + 1'b1);
			r.col = '0;
		end else begin
			r.row = p.row;
			r.col = c1;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/im2col_ag_div.sv
// Pipelined restoring divider: flat output index by output width, two
// quotient bits per stage. Depends on im2col_ag_pkg and the assertion macros.
`include "im2col_tile8_address_generator_core_macros.svh"

module im2col_ag_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_vld,
	input  logic [im2col_ag_pkg::DIVIDEND_W-1:0]   in_dividend,
	input  im2col_ag_pkg::side_t                   in_side,
	input  logic [im2col_ag_pkg::DIM_W-1:0]        divisor,
	output logic                                   out_vld,
	output logic [im2col_ag_pkg::DIVIDEND_W-1:0]   out_quo,
	output logic [im2col_ag_pkg::DIM_W-1:0]        out_rem,
	output im2col_ag_pkg::side_t                   out_side
);

	localparam int S  = im2col_ag_pkg::DIV_STAGES;
	localparam int DW = im2col_ag_pkg::DIVIDEND_W;
	localparam int RW = im2col_ag_pkg::DIM_W;

	logic [S-1:0]          vld_s;
	logic [DW-1:0]         dvd_s  [S];
	logic [DW-1:0]         quo_s  [S];
	logic [RW-1:0]         rem_s  [S];
	im2col_ag_pkg::side_t  side_s [S];

	logic [DW-1:0]         src_dvd [S];
	logic [DW-1:0]         src_quo [S];
	logic [RW-1:0]         src_rem [S];
	im2col_ag_pkg::side_t  src_side [S];
	logic [DW-1:0]         nxt_dvd [S];
	logic [DW-1:0]         nxt_quo [S];
	logic [RW-1:0]         nxt_rem [S];

	for (genvar k = 0; k < S; k++) begin : g_src
		if (k == 0) begin : g_first
			assign src_dvd[k]  = in_dividend;
			assign src_quo[k]  = '0;
			assign src_rem[k]  = '0;
			assign src_side[k] = in_side;
		end else begin : g_next
			assign src_dvd[k]  = dvd_s[k-1];
			assign src_quo[k]  = quo_s[k-1];
			assign src_rem[k]  = rem_s[k-1];
			assign src_side[k] = side_s[k-1];
		end
	end

	always_comb begin
		logic [RW:0]   t;
		logic [RW-1:0] r;
		logic [DW-1:0] d;
		logic [DW-1:0] q;
		for (int k = 0; k < S; k++) begin
			r = src_rem[k];
			d = src_dvd[k];
			q = src_quo[k];
			for (int j = 0; j < im2col_ag_pkg::DIV_STEP; j++) begin
				t = {r, d[DW-1]};
				d = {d[DW-2:0], 1'b0};
				if (t >= {1'b0, divisor}) begin
					t = t - {1'b0, divisor};
					q = {q[DW-2:0], 1'b1};
				end else begin
					q = {q[DW-2:0], 1'b0};
				end
				r = t[RW-1:0];
			end
			nxt_dvd[k] = d;
			nxt_quo[k] = q;
			nxt_rem[k] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[S-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < S; k++) begin
			dvd_s[k]  <= nxt_dvd[k];
			quo_s[k]  <= nxt_quo[k];
			rem_s[k]  <= nxt_rem[k];
			side_s[k] <= src_side[k];
		end
	end

	assign out_vld  = vld_s[S-1];
	assign out_quo  = quo_s[S-1];
	assign out_rem  = rem_s[S-1];
	assign out_side = side_s[S-1];

	`IM2COL_AG_ASSERT(a_div_latency, clk, arst_n, out_vld |-> $past(in_vld, S), "divider output without matching input transfer")

endmodule

>>> hw/rtl/im2col_ag_lane.sv
// One lane of the address datapath: scale and offset, bounds check with the
// row multiply, then the final address sum. Depends on im2col_ag_pkg.
module im2col_ag_lane (
	input  logic                                  clk,
	input  im2col_ag_pkg::lane_cfg_t              cfg,
	input  im2col_ag_pkg::pos_t                   pos,
	input  logic [im2col_ag_pkg::KOFF_W-1:0]      ky,
	input  logic [im2col_ag_pkg::KOFF_W-1:0]      kx,
	input  logic [im2col_ag_pkg::ADDR_W-1:0]      chan_base,
	output logic [im2col_ag_pkg::ADDR_W-1:0]      addr,
	output logic                                  pad
);

	localparam int YW  = im2col_ag_pkg::Y_W;
	localparam int XW  = im2col_ag_pkg::X_W;
	localparam int DW  = im2col_ag_pkg::DIM_W;
	localparam int PW  = im2col_ag_pkg::PLANE_W;
	localparam int AW  = im2col_ag_pkg::ADDR_W;
	localparam int RPW = im2col_ag_pkg::ROW_PROD_W;
	localparam int CPW = im2col_ag_pkg::COL_PROD_W;

	logic [RPW-1:0] ry;
	logic [CPW-1:0] rx;
	logic [YW-1:0]  y_nxt;
	logic [XW-1:0]  x_nxt;
	logic           in_nxt;

	logic [YW-1:0]  y_s3;
	logic [XW-1:0]  x_s3;
	logic [PW-1:0]  yiw_s4;
	logic [DW-1:0]  x_s4;
	logic           in_s4;
	logic [AW-1:0]  addr_s5;
	logic           pad_s5;

	assign ry    = RPW'(pos.row) * RPW'(cfg.stride_y);
	assign rx    = CPW'(pos.col) * CPW'(cfg.stride_x);
	assign y_nxt = YW'(ry) + YW'(ky) - YW'(cfg.pad_top);
	assign x_nxt = XW'(rx) + XW'(kx) - XW'(cfg.pad_left);

	assign in_nxt = cfg.ow_nz
		&& !y_s3[YW-1] && (y_s3[YW-2:0] < (YW-1)'(cfg.input_height))
		&& !x_s3[XW-1] && (x_s3[XW-2:0] < (XW-1)'(cfg.input_width));

	always_ff @(posedge clk) begin
		y_s3    <= y_nxt;
		x_s3    <= x_nxt;
		yiw_s4  <= PW'(y_s3[DW-1:0]) * PW'(cfg.input_width);
		x_s4    <= x_s3[DW-1:0];
		in_s4   <= in_nxt;
		addr_s5 <= in_s4 ? AW'(chan_base + AW'(yiw_s4) + AW'(x_s4)) : '0;
		pad_s5  <= !in_s4;
	end

	assign addr = addr_s5;
	assign pad  = pad_s5;

endmodule

>>> hw/rtl/im2col_tile8_address_generator_core.sv
// im2col gather-address generator for tiles of eight output positions.
// One item per cycle. The pipeline runs from the start transfer to done through
// the 12-stage divider (two quotient bits a stage), then two lane-wrap stages
// and three address stages. busy stays low; done cannot stall.
// Reset clears all valid bits and loads the config registers with defaults.
// Depends on im2col_ag_pkg, im2col_ag_div, im2col_ag_lane and the macro header.
`include "im2col_tile8_address_generator_core_macros.svh"

module im2col_tile8_address_generator_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [im2col_ag_pkg::DIVIDEND_W-1:0]   tile_start,
	input  logic [im2col_ag_pkg::CHAN_W-1:0]       channel,
	input  logic [im2col_ag_pkg::KOFF_W-1:0]       kernel_y_offset,
	input  logic [im2col_ag_pkg::KOFF_W-1:0]       kernel_x_offset,
	input  logic                                   cfg_we,
	input  logic [2:0]                             cfg_addr,
	input  logic [im2col_ag_pkg::DIM_W-1:0]        cfg_wdata,
	output logic                                   done,
	output logic [im2col_ag_pkg::ADDR_W-1:0]       addr_lane0,
	output logic [im2col_ag_pkg::ADDR_W-1:0]       addr_lane1,
	output logic [im2col_ag_pkg::ADDR_W-1:0]       addr_lane2,
	output logic [im2col_ag_pkg::ADDR_W-1:0]       addr_lane3,
	output logic [im2col_ag_pkg::ADDR_W-1:0]       addr_lane4,
	output logic [im2col_ag_pkg::ADDR_W-1:0]       addr_lane5,
	output logic [im2col_ag_pkg::ADDR_W-1:0]       addr_lane6,
	output logic [im2col_ag_pkg::ADDR_W-1:0]       addr_lane7,
	output logic [im2col_ag_pkg::LANES-1:0]        pad_mask
);

	localparam int L    = im2col_ag_pkg::LANES;
	localparam int HALF = L / 2;
	localparam int DW   = im2col_ag_pkg::DIM_W;
	localparam int SW   = im2col_ag_pkg::SMALL_W;
	localparam int AW   = im2col_ag_pkg::ADDR_W;
	localparam int PW   = im2col_ag_pkg::PLANE_W;
	localparam int CW   = im2col_ag_pkg::CHAN_W;

	logic [DW-1:0] input_width_q;
	logic [DW-1:0] input_height_q;
	logic [DW-1:0] output_width_q;
	logic [SW-1:0] stride_x_q;
	logic [SW-1:0] stride_y_q;
	logic [SW-1:0] pad_left_q;
	logic [SW-1:0] pad_top_q;
	logic [PW-1:0] plane_q;

	logic                                  in_xfer;
	logic                                  div_vld;
	logic [im2col_ag_pkg::DIVIDEND_W-1:0]  div_quo;
	logic [DW-1:0]                         div_rem;
	im2col_ag_pkg::side_t                  div_side;
	im2col_ag_pkg::side_t                  in_side;

	im2col_ag_pkg::pos_t   pos1  [HALF];
	im2col_ag_pkg::pos_t   pos2  [L];
	im2col_ag_pkg::pos_t   pos_s1 [HALF];
	im2col_ag_pkg::pos_t   pos_s2 [L];
	im2col_ag_pkg::side_t  side_s1;
	im2col_ag_pkg::side_t  side_s2;
	logic [CW-1:0]         chan_s3;
	logic [AW-1:0]         cbase_s4;
	logic                  vld_s1;
	logic                  vld_s2;
	logic                  vld_s3;
	logic                  vld_s4;
	logic                  vld_s5;

	im2col_ag_pkg::lane_cfg_t  lane_cfg;
	logic [AW-1:0]             lane_addr [L];
	logic [L-1:0]              lane_pad;
	logic                      pad_addr_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_width_q  <= DW'(1);
			input_height_q <= DW'(1);
			output_width_q <= DW'(1);
			stride_x_q     <= SW'(1);
			stride_y_q     <= SW'(1);
			pad_left_q     <= '0;
			pad_top_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				im2col_ag_pkg::REG_INPUT_WIDTH:  input_width_q  <= cfg_wdata;
				im2col_ag_pkg::REG_INPUT_HEIGHT: input_height_q <= cfg_wdata;
				im2col_ag_pkg::REG_OUTPUT_WIDTH: output_width_q <= cfg_wdata;
				im2col_ag_pkg::REG_STRIDE_X:     stride_x_q     <= cfg_wdata[SW-1:0];
				im2col_ag_pkg::REG_STRIDE_Y:     stride_y_q     <= cfg_wdata[SW-1:0];
				im2col_ag_pkg::REG_PAD_LEFT:     pad_left_q     <= cfg_wdata[SW-1:0];
				im2col_ag_pkg::REG_PAD_TOP:      pad_top_q      <= cfg_wdata[SW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		plane_q <= PW'(input_width_q) * PW'(input_height_q);
	end

	assign busy    = 1'b0;
	assign in_xfer = start && !busy;
	assign in_side = '{channel: channel, ky: kernel_y_offset, kx: kernel_x_offset};

	im2col_ag_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (in_xfer),
		.in_dividend (tile_start),
		.in_side     (in_side),
		.divisor     (output_width_q),
		.out_vld     (div_vld),
		.out_quo     (div_quo),
		.out_rem     (div_rem),
		.out_side    (div_side)
	);

	always_comb begin
		pos1[0].row = {1'b0, div_quo};
		pos1[0].col = div_rem;
		for (int i = 1; i < HALF; i++) begin
			pos1[i] = im2col_ag_pkg::next_pos(pos1[i-1], output_width_q);
		end
	end

	always_comb begin
		for (int i = 0; i < HALF; i++) begin
			pos2[i] = pos_s1[i];
		end
		for (int i = HALF; i < L; i++) begin
			pos2[i] = im2col_ag_pkg::next_pos(pos2[i-1], output_width_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= div_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1   <= pos1;
		side_s1  <= div_side;
		pos_s2   <= pos2;
		side_s2  <= side_s1;
		chan_s3  <= side_s2.channel;
		cbase_s4 <= AW'(PW'(CW'(0)) + (PW + CW)'(chan_s3) * (PW + CW)'(plane_q));
	end

	assign lane_cfg = '{
		input_width:  input_width_q,
		input_height: input_height_q,
		stride_x:     stride_x_q,
		stride_y:     stride_y_q,
		pad_left:     pad_left_q,
		pad_top:      pad_top_q,
		ow_nz:        (output_width_q != '0)
	};

	for (genvar i = 0; i < L; i++) begin : g_lane
		im2col_ag_lane u_lane (
			.clk       (clk),
			.cfg       (lane_cfg),
			.pos       (pos_s2[i]),
			.ky        (side_s2.ky),
			.kx        (side_s2.kx),
			.chan_base (cbase_s4),
			.addr      (lane_addr[i]),
			.pad       (lane_pad[i])
		);
	end

	assign done       = vld_s5;
	assign pad_mask   = lane_pad;
	assign addr_lane0 = lane_addr[0];
	assign addr_lane1 = lane_addr[1];
	assign addr_lane2 = lane_addr[2];
	assign addr_lane3 = lane_addr[3];
	assign addr_lane4 = lane_addr[4];
	assign addr_lane5 = lane_addr[5];
	assign addr_lane6 = lane_addr[6];
	assign addr_lane7 = lane_addr[7];

	always_comb begin
		pad_addr_bad = 1'b0;
		for (int i = 0; i < L; i++) begin
			pad_addr_bad = pad_addr_bad || (lane_pad[i] && (lane_addr[i] != '0));
		end
	end

	`IM2COL_AG_ASSERT(a_done_latency, clk, arst_n, done |-> $past(start && !busy, im2col_ag_pkg::LATENCY), "done without a start transfer at the pipeline latency")
	`IM2COL_AG_ASSERT(a_lane_step, clk, arst_n, vld_s1 |-> ((pos_s1[1].col == DW'(pos_s1[0].col + 1'b1) && pos_s1[1].row == pos_s1[0].row) || (pos_s1[1].col == '0 && pos_s1[1].row == im2col_ag_pkg::ROW_W'(pos_s1[0].row + 1'b1))), "lane position is not one step past the previous lane")
	`IM2COL_AG_NEVER(a_pad_zero, clk, arst_n, done && pad_addr_bad, "padded lane with nonzero address")

endmodule
